// ----- hdl/jsu_pkg.sv -----
`timescale 1ns / 1ps

package jsu_pkg;

  // Input item modes
  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_BYTE  = 2'd1;
  localparam logic [1:0] MODE_END   = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_DATA   = 3'd0;
  localparam logic [2:0] ST_DONE   = 3'd1;
  localparam logic [2:0] ST_NOQUOT = 3'd2;
  localparam logic [2:0] ST_BADHEX = 3'd3;
  localparam logic [2:0] ST_UNTERM = 3'd4;

  // Parser phase codes
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_STR  = 2'd1;
  localparam logic [1:0] PH_ESC  = 2'd2;
  localparam logic [1:0] PH_HEX  = 2'd3;

  localparam logic [7:0] CHAR_QUOTE = 8'h22;
  localparam logic [7:0] CHAR_BSL   = 8'h5C;
  localparam logic [7:0] CHAR_U     = 8'h75;

  // Most results one input item can produce
  localparam int unsigned NumRes = 3;

  typedef struct packed {
    logic [1:0]  phase;
    logic [1:0]  hex_cnt;
    logic [15:0] code_point;
  } state_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [2:0] status;
    logic       last;
  } res_t;

endpackage

// ----- hdl/jsu_in_if.sv -----
`timescale 1ns / 1ps

interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] in_byte;

  modport source (output valid, output mode, output in_byte, input ready);
  modport sink   (input valid, input mode, input in_byte, output ready);
endinterface

// ----- hdl/jsu_out_if.sv -----
`timescale 1ns / 1ps

interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [2:0] status;
  logic       last;

  modport source (output valid, output out_byte, output status, output last, input ready);
  modport sink   (input valid, input out_byte, input status, input last, output ready);
endinterface

// ----- hdl/jsu_decode.sv -----
`timescale 1ns / 1ps

// Next-state and result generation for one input byte.
module jsu_decode import jsu_pkg::*; (
  input  state_t              cur_i,
  input  logic [1:0]          mode_i,
  input  logic [7:0]          in_byte_i,
  output state_t              nxt_o,
  output res_t [NumRes-1:0]   res_o,
  output logic [1:0]          res_cnt_o
);

  logic       hex_ok;
  logic [3:0] hex_val;
  logic [7:0] esc_byte;
  logic [15:0] cp_new;
  logic [1:0] n;

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (in_byte_i >= 8'h30 && in_byte_i <= 8'h39) begin
      hex_val = 4'(in_byte_i - 8'h30);
    end else if (in_byte_i >= 8'h61 && in_byte_i <= 8'h66) begin
      hex_val = 4'(in_byte_i - 8'h57);
    end else if (in_byte_i >= 8'h41 && in_byte_i <= 8'h46) begin
      hex_val = 4'(in_byte_i - 8'h37);
    end else begin
      hex_ok = 1'b0;
    end
  end

  always_comb begin
    case (in_byte_i)
      8'h6E:   esc_byte = 8'h0A;
      8'h72:   esc_byte = 8'h0D;
      8'h74:   esc_byte = 8'h09;
      8'h62:   esc_byte = 8'h08;
      8'h66:   esc_byte = 8'h0C;
      default: esc_byte = in_byte_i;
    endcase
  end

  assign cp_new = {cur_i.code_point[11:0], hex_val};

  always_comb begin
    nxt_o = cur_i;
    res_o = '0;
    n     = 2'd0;
    case (mode_i)
      MODE_START: begin
        nxt_o.hex_cnt    = 2'd0;
        nxt_o.code_point = 16'd0;
        if (in_byte_i == CHAR_QUOTE) begin
          nxt_o.phase = PH_STR;
        end else begin
          nxt_o.phase      = PH_IDLE;
          res_o[0].status  = ST_NOQUOT;
          n                = 2'd1;
        end
      end
      MODE_END: begin
        if (cur_i.phase != PH_IDLE) begin
          nxt_o.phase     = PH_IDLE;
          nxt_o.hex_cnt   = 2'd0;
          res_o[0].status = ST_UNTERM;
          n               = 2'd1;
        end
      end
      MODE_BYTE: begin
        case (cur_i.phase)
          PH_STR: begin
            if (in_byte_i == CHAR_QUOTE) begin
              nxt_o.phase     = PH_IDLE;
              res_o[0].status = ST_DONE;
              n               = 2'd1;
            end else if (in_byte_i == CHAR_BSL) begin
              nxt_o.phase = PH_ESC;
            end else begin
              res_o[0].out_byte = in_byte_i;
              n                 = 2'd1;
            end
          end
          PH_ESC: begin
            if (in_byte_i == CHAR_U) begin
              nxt_o.phase      = PH_HEX;
              nxt_o.hex_cnt    = 2'd0;
              nxt_o.code_point = 16'd0;
            end else begin
              nxt_o.phase       = PH_STR;
              res_o[0].out_byte = esc_byte;
              n                 = 2'd1;
            end
          end
          PH_HEX: begin
            if (!hex_ok) begin
              nxt_o.phase     = PH_IDLE;
              nxt_o.hex_cnt   = 2'd0;
              res_o[0].status = ST_BADHEX;
              n               = 2'd1;
            end else begin
              nxt_o.code_point = cp_new;
              if (cur_i.hex_cnt != 2'd3) begin
                nxt_o.hex_cnt = cur_i.hex_cnt + 2'd1;
              end else begin
                nxt_o.hex_cnt = 2'd0;
                nxt_o.phase   = PH_STR;
                // UTF-8 encode, at most three bytes for a 16-bit code point
                if (cp_new < 16'h0080) begin
                  res_o[0].out_byte = cp_new[7:0];
                  n                 = 2'd1;
                end else if (cp_new < 16'h0800) begin
                  res_o[0].out_byte = 8'hC0 | {3'd0, cp_new[10:6]};
                  res_o[1].out_byte = 8'h80 | {2'd0, cp_new[5:0]};
                  n                 = 2'd2;
                end else begin
                  res_o[0].out_byte = 8'hE0 | {4'd0, cp_new[15:12]};
                  res_o[1].out_byte = 8'h80 | {2'd0, cp_new[11:6]};
                  res_o[2].out_byte = 8'h80 | {2'd0, cp_new[5:0]};
                  n                 = 2'd3;
                end
              end
            end
          end
          default: nxt_o.phase = PH_IDLE;
        endcase
      end
      default: ;
    endcase
    res_o[0].last = (n == 2'd1);
    res_o[1].last = (n == 2'd2);
    res_o[2].last = (n == 2'd3);
  end

  assign res_cnt_o = n;

endmodule

// ----- hdl/json_string_unescape_core.sv -----
`timescale 1ns / 1ps

// JSON string unescaper: one raw byte per input transfer, decoded bytes out.
//
// in_i  (sink):   mode (start / byte / end of input) and in_byte.
// out_o (source): out_byte, status and last, one result per transfer.
//   An input byte yields zero to three results; last marks the final one.
//
// Each accepted byte is decoded in the cycle it is taken and its results are
// written into a small result queue (2**FifoAw entries); out_o is driven from
// the queue, never combinationally from in_i. Throughput is one input byte per
// cycle while in_i.ready is high; in_i.ready depends only on queue occupancy,
// never combinationally on out_o.ready, and stays high while at least three
// entries are free. With the default depth a \uXXXX escape yielding three bytes
// does not stall a stream drained at one result per cycle.
//
// Reset clears the parser to idle and empties the queue. When the receiver
// stalls, results wait in the queue; input is held off once fewer than three entries are free.
module json_string_unescape_core import jsu_pkg::*; #(
  parameter int unsigned FifoAw = 3
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  jsu_in_if.sink    in_i,
  jsu_out_if.source out_o
);

  localparam int unsigned Depth = 2 ** FifoAw;
  localparam int unsigned CntW  = FifoAw + 1;

  state_t              state_q, state_d;
  res_t [NumRes-1:0]   res;
  logic [1:0]          res_cnt;

  res_t                mem_q [Depth];
  logic [FifoAw-1:0]   wptr_q, rptr_q;
  logic [CntW-1:0]     count_q, count_d;

  logic in_acc, out_acc;
  logic [CntW-1:0] push_n;

  jsu_decode u_decode (
    .cur_i     (state_q),
    .mode_i    (in_i.mode),
    .in_byte_i (in_i.in_byte),
    .nxt_o     (state_d),
    .res_o     (res),
    .res_cnt_o (res_cnt)
  );

  // Room for a worst-case item (three results) before taking another byte
  assign in_i.ready = (count_q <= CntW'(Depth - NumRes));
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_acc    = out_o.valid && out_o.ready;
  assign push_n     = in_acc ? CntW'(res_cnt) : '0;
  assign count_d    = count_q + push_n - CntW'(out_acc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (in_acc) begin
        state_q <= state_d;
      end
      wptr_q  <= wptr_q + FifoAw'(push_n);
      if (out_acc) begin
        rptr_q <= rptr_q + FifoAw'(1);
      end
      count_q <= count_d;
    end
  end

  // Queue storage, no reset needed
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NumRes; k++) begin
      if (in_acc && (2'(k) < res_cnt)) begin
        mem_q[wptr_q + FifoAw'(k)] <= res[k];
      end
    end
  end

  assign out_o.valid    = (count_q != '0);
  assign out_o.out_byte = mem_q[rptr_q].out_byte;
  assign out_o.status   = mem_q[rptr_q].status;
  assign out_o.last     = mem_q[rptr_q].last;

  // Queue never overfills
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("result queue overflow");

  // Digit counter only runs inside a \u sequence
  a_hex_in_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.hex_cnt != 2'd0) |-> (state_q.phase == PH_HEX))
    else $error("hex digit count outside hex phase");

  // Plain bytes while idle produce nothing and leave the parser idle
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_i.mode == MODE_BYTE && state_q.phase == PH_IDLE)
      |=> (count_q <= $past(count_q)) && (state_q.phase == PH_IDLE))
    else $error("idle parser produced output");

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

// Self-checking bench for json_string_unescape_core.
module tb_top;
  import jsu_pkg::*;

  // The package stops at end of input; the fourth mode code is reserved and ignored
  localparam logic [1:0] MODE_RSVD = 2'd3;
  localparam int unsigned RandItems = 380;
  localparam int unsigned MaxReports = 10;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] in_byte;
  } raw_item_t;

  logic clk;
  logic rst_n;

  jsu_in_if  in_if ();
  jsu_out_if out_if ();

  json_string_unescape_core dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  raw_item_t raw_stream[$];      // bytes still to be offered to the parser
  res_t      pending_results[$]; // decoded results not yet seen on out_o

  int unsigned total_items;
  int unsigned accepted_cnt = 0;
  int unsigned errors = 0;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  // Shadow of the parser state
  logic [1:0]  ph = PH_IDLE;
  logic [1:0]  hex_cnt = 2'd0;
  logic [15:0] cp = 16'h0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Idle mix by how far through the stream we are: receiver-heavy back-pressure
  // first, then sender-heavy gaps swapped round, then full rate.
  always @* begin
    if (accepted_cnt < total_items / 3) begin
      send_idle_pct = 29;
      recv_idle_pct = 62;
    end else if (accepted_cnt < (2 * total_items) / 3) begin
      send_idle_pct = 62;
      recv_idle_pct = 29;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  end

  function automatic int hex_val(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  function automatic res_t mk_res(input logic [7:0] b, input logic [2:0] s);
    return '{out_byte: b, status: s, last: 1'b0};
  endfunction

  // Advances the shadow parser by one accepted byte and queues what it emits.
  task automatic decode_step(input logic [1:0] mode, input logic [7:0] b);
    res_t burst[$];
    int   d;
    logic [7:0] esc;
    if (mode == MODE_START) begin
      hex_cnt = 2'd0;
      cp      = 16'h0;
      if (b == CHAR_QUOTE) begin
        ph = PH_STR;
      end else begin
        ph = PH_IDLE;
        burst = {burst, mk_res(8'h00, ST_NOQUOT)};
      end
    end else if (mode == MODE_END) begin
      if (ph != PH_IDLE) begin
        ph      = PH_IDLE;
        hex_cnt = 2'd0;
        burst = {burst, mk_res(8'h00, ST_UNTERM)};
      end
    end else if (mode == MODE_BYTE) begin
      case (ph)
        PH_STR: begin
          if (b == CHAR_QUOTE) begin
            ph = PH_IDLE;
            burst = {burst, mk_res(8'h00, ST_DONE)};
          end else if (b == CHAR_BSL) begin
            ph = PH_ESC;
          end else begin
            burst = {burst, mk_res(b, ST_DATA)};
          end
        end
        PH_ESC: begin
          if (b == CHAR_U) begin
            ph      = PH_HEX;
            hex_cnt = 2'd0;
            cp      = 16'h0;
          end else begin
            case (b)
              "n":     esc = 8'h0A;
              "r":     esc = 8'h0D;
              "t":     esc = 8'h09;
              "b":     esc = 8'h08;
              "f":     esc = 8'h0C;
              default: esc = b;   // quote, backslash, slash and unknown bytes
            endcase
            ph = PH_STR;
            burst = {burst, mk_res(esc, ST_DATA)};
          end
        end
        PH_HEX: begin
          d = hex_val(b);
          if (d < 0) begin
            ph      = PH_IDLE;
            hex_cnt = 2'd0;
            burst = {burst, mk_res(8'h00, ST_BADHEX)};
          end else begin
            cp = {cp[11:0], 4'(d)};
            if (hex_cnt != 2'd3) begin
              hex_cnt = hex_cnt + 2'd1;
            end else begin
              hex_cnt = 2'd0;
              ph      = PH_STR;
              // UTF-8 encode, one to three bytes; surrogates are left alone
              if (cp < 16'h0080) begin
                burst = {burst, mk_res(cp[7:0], ST_DATA)};
              end else if (cp < 16'h0800) begin
                burst = {burst, mk_res({3'b110, cp[10:6]}, ST_DATA)};
                burst = {burst, mk_res({2'b10, cp[5:0]}, ST_DATA)};
              end else begin
                burst = {burst, mk_res({4'b1110, cp[15:12]}, ST_DATA)};
                burst = {burst, mk_res({2'b10, cp[11:6]}, ST_DATA)};
                burst = {burst, mk_res({2'b10, cp[5:0]}, ST_DATA)};
              end
            end
          end
        end
        default: ;        // stray bytes while idle change nothing
      endcase
    end
    // reserved mode: nothing at all
    if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
    pending_results = {pending_results, burst};
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------------
  function automatic void push_item(input logic [1:0] mode, input logic [7:0] b);
    raw_item_t it;
    it.mode    = mode;
    it.in_byte = b;
    raw_stream = {raw_stream, it};
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'("0") + 8'(n);
    // letters in either case
    return ($urandom_range(0, 1) ? 8'("a") : 8'("A")) + 8'(n) - 8'd10;
  endfunction

  function automatic logic [7:0] non_hex_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (hex_val(b) >= 0);
    return b;
  endfunction

  function automatic void push_unicode(input logic [15:0] v);
    push_item(MODE_BYTE, CHAR_BSL);
    push_item(MODE_BYTE, CHAR_U);
    for (int i = 3; i >= 0; i--) push_item(MODE_BYTE, hex_char(v[4*i +: 4]));
  endfunction

  // A well-formed string with random content, usually closed properly
  function automatic void add_random_string();
    int unsigned n_seg;
    int unsigned kind;
    int unsigned ending;
    logic [7:0]  b;
    push_item(MODE_START, CHAR_QUOTE);
    n_seg = $urandom_range(0, 8);
    repeat (n_seg) begin
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
        do b = 8'($urandom_range(0, 255)); while (b == CHAR_QUOTE || b == CHAR_BSL);
        push_item(MODE_BYTE, b);
      end else if (kind < 7) begin
        case ($urandom_range(0, 8))
          0:       b = CHAR_QUOTE;
          1:       b = CHAR_BSL;
          2:       b = "/";
          3:       b = "n";
          4:       b = "r";
          5:       b = "t";
          6:       b = "b";
          7:       b = "f";
          default: do b = 8'($urandom_range(0, 255)); while (b == CHAR_U);
        endcase
        push_item(MODE_BYTE, CHAR_BSL);
        push_item(MODE_BYTE, b);
      end else begin
        // spread code points over the one, two and three byte encodings
        case ($urandom_range(0, 2))
          0:       push_unicode(16'($urandom_range(0, 'h7F)));
          1:       push_unicode(16'($urandom_range('h80, 'h7FF)));
          default: push_unicode(16'($urandom_range('h800, 'hFFFF)));
        endcase
      end
    end
    ending = $urandom_range(0, 9);
    if (ending < 8) push_item(MODE_BYTE, CHAR_QUOTE);
    else if (ending == 8) push_item(MODE_END, 8'($urandom_range(0, 255)));
    // otherwise left open: the next start abandons it
  endfunction

  // Raw noise, or a \u escape cut short by a bad digit or end of input
  function automatic void add_noise();
    int unsigned n;
    if ($urandom_range(0, 1)) begin
      n = $urandom_range(1, 4);
      repeat (n) push_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
    end else begin
      push_item(MODE_START, CHAR_QUOTE);
      push_item(MODE_BYTE, CHAR_BSL);
      push_item(MODE_BYTE, CHAR_U);
      n = $urandom_range(0, 3);
      repeat (n) push_item(MODE_BYTE, hex_char(4'($urandom_range(0, 15))));
      if ($urandom_range(0, 2) != 0) push_item(MODE_BYTE, non_hex_byte());
      else push_item(MODE_END, 8'h00);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers raw_stream one transfer at a time, holds while stalled
  // ---------------------------------------------------------------------------
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_if.valid   <= 1'b0;
      in_if.mode    <= MODE_START;
      in_if.in_byte <= 8'h00;
    end else begin
      if (in_if.valid && in_if.ready) begin
        decode_step(in_if.mode, in_if.in_byte);
        accepted_cnt++;
      end
      if (in_if.valid && !in_if.ready) begin
        // transfer still pending: keep everything as it is
      end else if (raw_stream.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_if.valid   <= 1'b1;
        in_if.mode    <= raw_stream[0].mode;
        in_if.in_byte <= raw_stream[0].in_byte;
        void'(raw_stream.pop_front());
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each result transfer against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk or negedge rst_n) begin
    res_t got;
    res_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got = '{out_byte: out_if.out_byte, status: out_if.status, last: out_if.last};
        if (pending_results.size() == 0) begin
          errors++;
          if (errors <= MaxReports)
            $display("unexpected result: byte %h status %0d last %b",
                     got.out_byte, got.status, got.last);
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= MaxReports)
              $display("mismatch: exp byte %h status %0d last %b, got byte %h status %0d last %b",
                       want.out_byte, want.status, want.last,
                       got.out_byte, got.status, got.last);
          end
        end
      end
      out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, build the stream, drain, report
  // ---------------------------------------------------------------------------
  initial begin
    rst_n         = 1'b0;
    total_items   = 0;

    // Directed: idle corner cases first
    push_item(MODE_END,  8'hFF);        // end of input while idle
    push_item(MODE_BYTE, 8'hFF);        // byte before any start
    push_item(MODE_RSVD, 8'h22);        // reserved mode
    push_item(MODE_START, "x");         // start without a quote
    // extremes of the byte range, a control escape and the top code point
    push_item(MODE_START, CHAR_QUOTE);
    push_item(MODE_BYTE, 8'h00);
    push_item(MODE_BYTE, 8'hFF);
    push_item(MODE_BYTE, CHAR_BSL);
    push_item(MODE_BYTE, "n");
    push_unicode(16'hFFFF);
    push_item(MODE_BYTE, CHAR_QUOTE);
    // bad hex digit
    push_item(MODE_START, CHAR_QUOTE);
    push_item(MODE_BYTE, CHAR_BSL);
    push_item(MODE_BYTE, CHAR_U);
    push_item(MODE_BYTE, "0");
    push_item(MODE_BYTE, "g");
    // restart mid-string, then end of input right after a backslash
    push_item(MODE_START, CHAR_QUOTE);
    push_item(MODE_BYTE, "a");
    push_item(MODE_START, CHAR_QUOTE);
    push_item(MODE_BYTE, CHAR_BSL);
    push_item(MODE_END, 8'h00);

    while (raw_stream.size() < RandItems) begin
      if ($urandom_range(0, 99) < 85) add_random_string();
      else add_noise();
    end
    total_items = raw_stream.size();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_cnt != total_items) @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    // let any stray late results show up
    repeat (20) @(posedge clk);

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/jsu_pkg.sv
hdl/jsu_in_if.sv
hdl/jsu_out_if.sv
hdl/jsu_decode.sv
hdl/json_string_unescape_core.sv
tb/tb_top.sv
